[rtl/core/ntc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_pkg: shared constants and types for the ntc thermistor temperature block
// widths, register map, fixed-point constants and divider status
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int SAMPLES_DEF = 16;

  localparam int SAMPLE_W = 12;
  localparam int TEMP_W   = 16;
  localparam int STATUS_W = 2;
  localparam int SUPPLY_W = 13;
  localparam int OHMS_W   = 20;
  localparam int BETA_W   = 14;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [SUPPLY_W-1:0] SUPPLY_RST  = 13'd3300;
  localparam logic [OHMS_W-1:0]   SERIES_RST  = 20'd10000;
  localparam logic [OHMS_W-1:0]   NOMINAL_RST = 20'd10000;
  localparam logic [BETA_W-1:0]   BETA_RST    = 14'd3950;

  typedef enum logic [1:0] {
    REG_SUPPLY  = 2'd0,
    REG_SERIES  = 2'd1,
    REG_NOMINAL = 2'd2,
    REG_BETA    = 2'd3
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID = 2'd0,
    ST_LOW   = 2'd1,
    ST_HIGH  = 2'd2
  } status_t;

  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] T0_CENTI  = 32'd29815;
  localparam logic [31:0] CENTI     = 32'd100;
  localparam logic [31:0] RECIP5    = 32'd419431;   // ceil(2^21 / 5)
  localparam int          SQ_STEPS  = 20;
  localparam int          SQ_CW     = 5;
  localparam int          MANT_W    = 31;
  localparam int          DIV_NW    = 61;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[rtl/core/ntc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_div: iterative restoring divider
// one quotient bit per cycle, done pulses after the last bit
// ----------------------------------------------------------------------------
module ntc_div #(
  parameter int NW = 61,
  parameter int DW = 42
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic [NW-1:0]      quotient,
  output ntc_pkg::div_stat_t stat
);
  import ntc_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DW:0]      sh;
  logic [DW+1:0]    trial;

  assign sh    = {rem, quo[NW-1]};
  assign trial = {1'b0, sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= sh[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule
`default_nettype wire

[rtl/core/ntc_thermistor_temperature.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature: ntc thermistor temperature from averaged samples
// beta-equation temperature in signed q8 celsius from SAMPLES divider readings
// ----------------------------------------------------------------------------
// Each sample transaction adds one millivolt reading to a running sum. Every
// SAMPLES-th sample closes a block: the sum is checked against ground and
// supply, and if it is in range the thermistor resistance ratio is formed,
// log2 of numerator and denominator is taken by normalizing and twenty
// squaring steps, ln(R/R0) and the beta denominator follow, and a 61-step
// restoring division gives kelvin in q12 before conversion to q8 celsius. All
// products go through one registered 32x32 multiplier under a small sequencer,
// so a closing sample keeps sample_ready low until the sequencer is back in
// idle, whether it runs through the two normalize loops, the two squaring
// runs and the divider or stops before the division. A finished result
// sits in an output register so new samples are taken while it waits for
// result_ready; a second finished result waits in the sequencer with
// sample_ready low. Configuration is an apb-style port at byte addresses 0,
// 4, 8, 12.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature #(
  parameter int SAMPLES = ntc_pkg::SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire logic [ntc_pkg::SAMPLE_W-1:0]  sample_mv,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0]  temp_q8,
  output logic [ntc_pkg::STATUS_W-1:0]       status,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ntc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [ntc_pkg::APB_DW-1:0]    pwdata,
  output logic [ntc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import ntc_pkg::*;

  // widths that follow from the block size
  localparam int SW    = $clog2(SAMPLES + 1);
  localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);
  localparam int CW    = $clog2(SAMPLES);
  localparam int FW    = SUPPLY_W + SW;        // supply * SAMPLES
  localparam int XW    = FW + OHMS_W;          // ratio numerator / denominator
  localparam int EW    = $clog2(XW);
  localparam int LW    = EW + 20;              // log2 in q20
  localparam int TQW   = LW + 15;              // t0 * ln in q20
  localparam int DDW   = ((TQW > 41) ? TQW : 41) + 2;
  localparam int ZW    = 19;

  typedef enum logic [18:0] {
    S_IDLE  = 19'b0000000000000000001,
    S_FULL  = 19'b0000000000000000010,
    S_CHECK = 19'b0000000000000000100,
    S_NUM   = 19'b0000000000000001000,
    S_DEN   = 19'b0000000000000010000,
    S_LOAD  = 19'b0000000000000100000,
    S_NORM  = 19'b0000000000001000000,
    S_SQ    = 19'b0000000000010000000,
    S_SQ2   = 19'b0000000000100000000,
    S_LN    = 19'b0000000001000000000,
    S_DD1   = 19'b0000000010000000000,
    S_DD2   = 19'b0000000100000000000,
    S_DD3   = 19'b0000001000000000000,
    S_DD4   = 19'b0000010000000000000,
    S_DIV   = 19'b0000100000000000000,
    S_CONV1 = 19'b0001000000000000000,
    S_CONV2 = 19'b0010000000000000000,
    S_CONV3 = 19'b0100000000000000000,
    S_DONE  = 19'b1000000000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [SUPPLY_W-1:0] supply_mv;
  logic [OHMS_W-1:0]   series_ohms;
  logic [OHMS_W-1:0]   nominal_ohms;
  logic [BETA_W-1:0]   beta_kelvin;

  // accumulator
  logic [SUM_W-1:0] sample_sum;
  logic [CW-1:0]    sample_count;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] blk_sum;

  // datapath registers
  logic [63:0]            prod;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [FW-1:0]          diff;
  logic [XW-1:0]          num_r;
  logic [XW-1:0]          den_r;
  logic [XW-1:0]          w;
  logic [EW-1:0]          e;
  logic [MANT_W-1:0]      m;
  logic [19:0]            frac;
  logic [SQ_CW-1:0]       sq_cnt;
  logic                   which;
  logic [LW-1:0]          l2n;
  logic [LW-1:0]          l2d;
  logic                   neg;
  logic [TQW-1:0]         tq;
  logic signed [DDW-1:0]  dd;
  logic [ZW-1:0]          z;
  logic signed [TEMP_W-1:0] res_temp;
  logic [STATUS_W-1:0]      res_status;

  // combinational helpers
  logic [FW-1:0]          full;
  logic [SUM_W+3:0]       s10;
  logic [FW+4:0]          full10;
  logic [FW+4:0]          s10_lim;
  logic [31:0]            sq_t;
  logic [19:0]            frac_next;
  logic signed [LW:0]     ld;
  logic [LW:0]            ld_mag;
  logic [40:0]            beta_q20;
  logic signed [DDW-1:0]  dd_next;
  logic [DIV_NW-1:0]      div_q;
  logic [40:0]            tk;
  logic [44:0]            tk10;
  logic signed [45:0]     y;
  logic signed [45:0]     y_sh;
  logic                   div_start;
  div_stat_t              div_stat;

  // ------------------------------------------------------------------------
  // apb configuration port
  // ------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_mv    <= SUPPLY_RST;
      series_ohms  <= SERIES_RST;
      nominal_ohms <= NOMINAL_RST;
      beta_kelvin  <= BETA_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SUPPLY:  supply_mv    <= pwdata[SUPPLY_W-1:0];
        REG_SERIES:  series_ohms  <= pwdata[OHMS_W-1:0];
        REG_NOMINAL: nominal_ohms <= pwdata[OHMS_W-1:0];
        REG_BETA:    beta_kelvin  <= pwdata[BETA_W-1:0];
        default:     supply_mv    <= supply_mv;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SUPPLY:  prdata = APB_DW'(supply_mv);
      REG_SERIES:  prdata = APB_DW'(series_ohms);
      REG_NOMINAL: prdata = APB_DW'(nominal_ohms);
      REG_BETA:    prdata = APB_DW'(beta_kelvin);
      default:     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------------
  // shared multiplier: operands picked by state, product registered
  // ------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FULL:  begin mul_a = 32'(supply_mv);    mul_b = 32'(SAMPLES);   end
      S_NUM:   begin mul_a = 32'(series_ohms);  mul_b = 32'(blk_sum);   end
      S_DEN:   begin mul_a = 32'(diff);         mul_b = 32'(nominal_ohms); end
      S_SQ:    begin mul_a = 32'(m);            mul_b = 32'(m);         end
      S_LN:    begin mul_a = 32'(ld_mag);       mul_b = LN2_Q30;        end
      S_DD1:   begin mul_a = 32'(prod[LW+29:30]); mul_b = T0_CENTI;     end
      S_DD2:   begin mul_a = 32'(beta_kelvin);  mul_b = CENTI;          end
      S_DD3:   begin mul_a = 32'(beta_kelvin);  mul_b = T0_CENTI;       end
      S_CONV2: begin mul_a = 32'(z);            mul_b = RECIP5;         end
      default: begin mul_a = '0;                mul_b = '0;             end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ------------------------------------------------------------------------
  // combinational helpers
  // ------------------------------------------------------------------------
  assign sum_next = sample_sum + SUM_W'(sample_mv);
  assign full     = prod[FW-1:0];
  assign s10      = {1'b0, blk_sum, 3'b000} + {3'b000, blk_sum, 1'b0};
  assign full10   = {1'b0, full, 3'b000} + {3'b000, full, 1'b0};
  assign s10_lim  = (FW+5)'(s10) + (FW+5)'(SAMPLES);

  // squaring step: q30 renormalize
  assign sq_t      = prod[61:30];
  assign frac_next = {frac[18:0], sq_t[31]};

  // ln magnitude from log2 difference
  assign ld     = $signed({1'b0, l2n}) - $signed({1'b0, l2d});
  assign ld_mag = ld[LW] ? (LW+1)'(-ld) : (LW+1)'(ld);

  // beta * 100 in q20 plus signed t0 * ln
  assign beta_q20 = {prod[20:0], 20'b0};
  assign dd_next  = $signed(DDW'(beta_q20))
                  + (neg ? -$signed(DDW'(tq)) : $signed(DDW'(tq)));

  // kelvin q12 to rounded q8 celsius
  assign tk   = (div_q > DIV_NW'(64'h100_0000_0000)) ? 41'h100_0000_0000 : div_q[40:0];
  assign tk10 = {1'b0, tk, 3'b000} + {3'b000, tk, 1'b0};
  assign y    = $signed({1'b0, tk10}) - 46'sd11188144;
  assign y_sh = y >>> 5;

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  assign sample_ready = (state == S_IDLE);
  assign div_start    = (state == S_DD4) && (dd != '0) && !dd[DDW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_sum   <= '0;
      sample_count <= '0;
      result_valid <= 1'b0;
    end else begin
      // output register loads a new result or empties
      if ((state == S_DONE) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            if (sample_count == CW'(SAMPLES - 1)) begin
              sample_sum   <= '0;
              sample_count <= '0;
              state        <= S_FULL;
            end else begin
              sample_sum   <= sum_next;
              sample_count <= sample_count + 1'b1;
            end
          end
        end
        S_FULL:  state <= S_CHECK;
        S_CHECK: begin
          // ground test first, then supply or zero series resistance, then zero nominal resistance or beta
          if ((SUM_W+4)'(s10) <= (SUM_W+4)'(SAMPLES)) begin
            state <= S_DONE;
          end else if ((s10_lim >= full10) || (series_ohms == '0)) begin
            state <= S_DONE;
          end else if ((nominal_ohms == '0) || (beta_kelvin == '0)) begin
            state <= S_DONE;
          end else begin
            state <= S_NUM;
          end
        end
        S_NUM:  state <= S_DEN;
        S_DEN:  state <= S_LOAD;
        S_LOAD: state <= S_NORM;
        S_NORM: begin
          if (w[XW-1] || (e == '0)) begin
            state <= S_SQ;
          end
        end
        S_SQ:  state <= S_SQ2;
        S_SQ2: begin
          if (sq_cnt == SQ_CW'(SQ_STEPS - 1)) begin
            state <= which ? S_LN : S_NORM;
          end else begin
            state <= S_SQ;
          end
        end
        S_LN:  state <= S_DD1;
        S_DD1: state <= S_DD2;
        S_DD2: state <= S_DD3;
        S_DD3: state <= S_DD4;
        S_DD4: begin
          state <= div_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_CONV1;
          end
        end
        S_CONV1: begin
          state <= ((y >= 46'sd5242720) || (y < -46'sd5242720)) ? S_DONE : S_CONV2;
        end
        S_CONV2: state <= S_CONV3;
        S_CONV3: state <= S_DONE;
        S_DONE: begin
          // output register free or emptying this cycle
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        blk_sum <= sum_next;
      end
      S_CHECK: begin
        diff <= full - FW'(blk_sum);
        if ((SUM_W+4)'(s10) <= (SUM_W+4)'(SAMPLES)) begin
          res_temp   <= '0;
          res_status <= ST_LOW;
        end else if ((s10_lim >= full10) || (series_ohms == '0)) begin
          res_temp   <= '0;
          res_status <= ST_HIGH;
        end else if ((nominal_ohms == '0) || (beta_kelvin == '0)) begin
          res_temp   <= TEMP_MIN;     // tends to absolute zero
          res_status <= ST_VALID;
        end else begin
          res_temp   <= '0;
          res_status <= ST_VALID;
        end
      end
      S_DEN: begin
        num_r <= prod[XW-1:0];
      end
      S_LOAD: begin
        den_r <= prod[XW-1:0];
        w     <= num_r;
        e     <= EW'(XW - 1);
        which <= 1'b0;
      end
      S_NORM: begin
        if (w[XW-1] || (e == '0)) begin
          m      <= w[XW-1 -: MANT_W];
          frac   <= '0;
          sq_cnt <= '0;
        end else begin
          w <= {w[XW-2:0], 1'b0};
          e <= e - 1'b1;
        end
      end
      S_SQ2: begin
        m      <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        frac   <= frac_next;
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == SQ_CW'(SQ_STEPS - 1)) begin
          if (which) begin
            l2d <= {e, frac_next};
          end else begin
            l2n   <= {e, frac_next};
            w     <= den_r;
            e     <= EW'(XW - 1);
            which <= 1'b1;
          end
        end
      end
      S_LN: begin
        neg <= ld[LW];
      end
      S_DD2: begin
        tq <= prod[TQW-1:0];
      end
      S_DD3: begin
        dd <= dd_next;
      end
      S_DD4: begin
        if (dd == '0) begin
          res_temp <= TEMP_MAX;
        end else if (dd[DDW-1]) begin
          res_temp <= TEMP_MIN;       // negative kelvin
        end
      end
      S_CONV1: begin
        z <= ZW'(y_sh + 46'sd163840);
        if (y >= 46'sd5242720) begin
          res_temp <= TEMP_MAX;
        end else if (y < -46'sd5242720) begin
          res_temp <= TEMP_MIN;
        end
      end
      S_CONV3: begin
        // floor(z / 5) less the offset of 32768 steps
        res_temp <= $signed(prod[36:21] ^ 16'h8000);
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          temp_q8 <= res_temp;
          status  <= res_status;
        end
      end
      default: begin
        blk_sum <= blk_sum;
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // beta-equation divider: (beta * t0 << 32) / denominator
  // ------------------------------------------------------------------------
  ntc_div #(
    .NW (DIV_NW),
    .DW (DDW - 1)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({prod[28:0], 32'b0}),
    .divisor  (dd[DDW-2:0]),
    .quotient (div_q),
    .stat     (div_stat)
  );

`ifndef ASSERT_OFF
  a_status_zero_temp: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_VALID) |-> (temp_q8 == '0))
    else $error("temperature not zero with nonzero status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status != 2'd3))
    else $error("undefined status code");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> !div_stat.busy)
    else $error("divider busy while taking samples");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (32'(sample_count) < SAMPLES))
    else $error("sample count beyond block size");
`endif

endmodule
`default_nettype wire
